// File: rtl/jmsv_pkg.sv
// Package for the synchronized joint velocity block.
// Holds widths, register indices and reset values, the per-joint divider lane type and the stage type; no dependencies.
package jmsv_pkg;

  localparam int NUM_JOINTS = 6;
  localparam int ANG_W      = 16;
  localparam int DIFF_W     = 17;
  localparam int ABS_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int NUM_W      = 48;
  localparam int FRAC_SH    = 14;
  localparam int REM_W      = NUM_W - FRAC_SH;
  localparam int QUO_W      = 19;
  localparam int VEL_W      = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DAT_W  = 16;
  localparam int THR_W      = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FACTOR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_THR   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE    = CFG_IDX_W'(3);

  localparam logic [15:0]      RST_TOP_SPEED    = 16'd2048;
  localparam logic [15:0]      RST_ACCEL_FACTOR = 16'd16384;
  localparam logic [THR_W-1:0] RST_ARRIVE_THR   = 15'd123;
  localparam logic [15:0]      RST_VEL_SCALE    = 16'd15279;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  arrived;
    logic [ABS_W-1:0]      m;
    lane_t [NUM_JOINTS-1:0] lane;
  } div_stage_t;

endpackage

// File: rtl/jmsv_if.sv
// Channel interfaces: angle input, velocity result and register write.
// Depends on jmsv_pkg.
interface jmsv_in_if;
  logic valid;
  logic ready;
  logic signed [jmsv_pkg::ANG_W-1:0] target_angle_0;
  logic signed [jmsv_pkg::ANG_W-1:0] target_angle_1;
  logic signed [jmsv_pkg::ANG_W-1:0] target_angle_2;
  logic signed [jmsv_pkg::ANG_W-1:0] target_angle_3;
  logic signed [jmsv_pkg::ANG_W-1:0] target_angle_4;
  logic signed [jmsv_pkg::ANG_W-1:0] target_angle_5;
  logic signed [jmsv_pkg::ANG_W-1:0] present_angle_0;
  logic signed [jmsv_pkg::ANG_W-1:0] present_angle_1;
  logic signed [jmsv_pkg::ANG_W-1:0] present_angle_2;
  logic signed [jmsv_pkg::ANG_W-1:0] present_angle_3;
  logic signed [jmsv_pkg::ANG_W-1:0] present_angle_4;
  logic signed [jmsv_pkg::ANG_W-1:0] present_angle_5;
  modport source (output valid, target_angle_0, target_angle_1, target_angle_2,
                  target_angle_3, target_angle_4, target_angle_5, present_angle_0,
                  present_angle_1, present_angle_2, present_angle_3, present_angle_4,
                  present_angle_5, input ready);
  modport sink (input valid, target_angle_0, target_angle_1, target_angle_2,
                target_angle_3, target_angle_4, target_angle_5, present_angle_0,
                present_angle_1, present_angle_2, present_angle_3, present_angle_4,
                present_angle_5, output ready);
endinterface

interface jmsv_out_if;
  logic valid;
  logic ready;
  logic signed [jmsv_pkg::VEL_W-1:0] velocity_0;
  logic signed [jmsv_pkg::VEL_W-1:0] velocity_1;
  logic signed [jmsv_pkg::VEL_W-1:0] velocity_2;
  logic signed [jmsv_pkg::VEL_W-1:0] velocity_3;
  logic signed [jmsv_pkg::VEL_W-1:0] velocity_4;
  logic signed [jmsv_pkg::VEL_W-1:0] velocity_5;
  logic arrived;
  modport source (output valid, velocity_0, velocity_1, velocity_2, velocity_3,
                  velocity_4, velocity_5, arrived, input ready);
  modport sink (input valid, velocity_0, velocity_1, velocity_2, velocity_3,
                velocity_4, velocity_5, arrived, output ready);
endinterface

interface jmsv_cfg_if;
  logic valid;
  logic ready;
  logic [jmsv_pkg::CFG_IDX_W-1:0] index;
  logic [jmsv_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/jmsv_gain.sv
// Gain pipeline: top_speed * accel_factor * velocity_scale, shifted down 16 bits with rounding.
// Depends on jmsv_pkg.
module jmsv_gain (
  input  logic                          clk,
  input  logic [15:0]                   top_speed,
  input  logic [15:0]                   accel_factor,
  input  logic [15:0]                   velocity_scale,
  output logic [jmsv_pkg::GAIN_W-1:0]   gain
);
  logic [31:0] prod_r;
  logic [jmsv_pkg::GAIN_W-1:0] gain_r;
  logic [48:0] full;

  assign full = 49'(prod_r) * 49'(velocity_scale) + 49'(32768);

  always_ff @(posedge clk) begin
    prod_r <= 32'(top_speed) * 32'(accel_factor);
    gain_r <= full[16 +: jmsv_pkg::GAIN_W];
  end

  assign gain = gain_r;
endmodule

// File: rtl/jmsv_div_step.sv
// One restoring division step for all joint lanes, registered.
// Depends on jmsv_pkg.
module jmsv_div_step #(
  parameter int BIT = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  jmsv_pkg::div_stage_t    stage_in,
  output jmsv_pkg::div_stage_t    stage_out
);
  jmsv_pkg::div_stage_t stage_r, stage_nxt;
  logic [jmsv_pkg::REM_W-1:0] dsh;

  assign dsh = jmsv_pkg::REM_W'(stage_in.m) << BIT;

  always_comb begin
    stage_nxt = stage_in;
    for (int i = 0; i < jmsv_pkg::NUM_JOINTS; i++) begin
      if (stage_in.lane[i].rem >= dsh) begin
        stage_nxt.lane[i].rem      = stage_in.lane[i].rem - dsh;
        stage_nxt.lane[i].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;
endmodule

// File: rtl/joint_move_sync_velocity_top.sv
// Synchronized joint velocity top: error, leading axis, gain, divide, saturate.
// Depends on jmsv_pkg, jmsv_if, jmsv_gain and jmsv_div_step.
// Pipeline: 3 front stages, 19 divider steps and an output register between input
// beat and result beat; throughput one beat per cycle, a held result stalls all stages.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults.
module joint_move_sync_velocity_top (
  input  logic  clk,
  input  logic  rst_n,
  jmsv_in_if.sink    in_,
  jmsv_out_if.source out_,
  jmsv_cfg_if.sink   cfg_
);
  localparam int NJ = jmsv_pkg::NUM_JOINTS;
  localparam int QW = jmsv_pkg::QUO_W;

  logic [15:0] top_speed_r, accel_factor_r, velocity_scale_r;
  logic [jmsv_pkg::THR_W-1:0] arrive_thr_r;
  logic [jmsv_pkg::GAIN_W-1:0] gain;

  logic adv;
  logic signed [jmsv_pkg::ANG_W-1:0] tgt [NJ];
  logic signed [jmsv_pkg::ANG_W-1:0] pre [NJ];

  logic v1_r, v2_r;
  logic [jmsv_pkg::ABS_W-1:0] abs1_r [NJ];
  logic [NJ-1:0] neg1_r, neg2_r;
  logic [jmsv_pkg::ABS_W-1:0] abs2_r [NJ];
  logic [jmsv_pkg::ABS_W-1:0] m2_r, m_nxt;
  logic arr2_r;

  jmsv_pkg::div_stage_t s3_r;
  jmsv_pkg::div_stage_t chain [QW+1];

  logic out_v_r, out_arr_r;
  logic signed [jmsv_pkg::VEL_W-1:0] vel_r [NJ];
  logic signed [jmsv_pkg::VEL_W-1:0] vel_nxt [NJ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r      <= jmsv_pkg::RST_TOP_SPEED;
      accel_factor_r   <= jmsv_pkg::RST_ACCEL_FACTOR;
      arrive_thr_r     <= jmsv_pkg::RST_ARRIVE_THR;
      velocity_scale_r <= jmsv_pkg::RST_VEL_SCALE;
    end else if (cfg_.valid) begin
      unique case (cfg_.index)
        jmsv_pkg::REG_TOP_SPEED:    top_speed_r      <= cfg_.data;
        jmsv_pkg::REG_ACCEL_FACTOR: accel_factor_r   <= cfg_.data;
        jmsv_pkg::REG_ARRIVE_THR:   arrive_thr_r     <= cfg_.data[jmsv_pkg::THR_W-1:0];
        jmsv_pkg::REG_VEL_SCALE:    velocity_scale_r <= cfg_.data;
        default: ;
      endcase
    end
  end
  assign cfg_.ready = 1'b1;

  jmsv_gain u_gain (
    .clk            (clk),
    .top_speed      (top_speed_r),
    .accel_factor   (accel_factor_r),
    .velocity_scale (velocity_scale_r),
    .gain           (gain)
  );

  assign adv       = !out_v_r || out_.ready;
  assign in_.ready = adv;

  assign tgt[0] = in_.target_angle_0;  assign pre[0] = in_.present_angle_0;
  assign tgt[1] = in_.target_angle_1;  assign pre[1] = in_.present_angle_1;
  assign tgt[2] = in_.target_angle_2;  assign pre[2] = in_.present_angle_2;
  assign tgt[3] = in_.target_angle_3;  assign pre[3] = in_.present_angle_3;
  assign tgt[4] = in_.target_angle_4;  assign pre[4] = in_.present_angle_4;
  assign tgt[5] = in_.target_angle_5;  assign pre[5] = in_.present_angle_5;

  // stage 1: per-joint error magnitude and sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_.valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [jmsv_pkg::DIFF_W-1:0] d;
    if (adv) begin
      for (int i = 0; i < NJ; i++) begin
        d = jmsv_pkg::DIFF_W'(tgt[i]) - jmsv_pkg::DIFF_W'(pre[i]);
        neg1_r[i] <= d[jmsv_pkg::DIFF_W-1];
        abs1_r[i] <= d[jmsv_pkg::DIFF_W-1] ? jmsv_pkg::ABS_W'(-d)
                                            : jmsv_pkg::ABS_W'(d);
      end
    end
  end

  // stage 2: leading axis and arrival
  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < NJ; i++) begin
      if (abs1_r[i] > m_nxt) m_nxt = abs1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r   <= m_nxt;
      arr2_r <= (m_nxt == '0) || (m_nxt < jmsv_pkg::ABS_W'(arrive_thr_r));
      abs2_r <= abs1_r;
      neg2_r <= neg1_r;
    end
  end

  // stage 3: dividend = (|d| * gain + m * 2^13) >> 14
  always_ff @(posedge clk) begin
    logic [jmsv_pkg::NUM_W-1:0] num;
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s3_r.valid   <= v2_r;
      s3_r.arrived <= arr2_r;
      s3_r.m       <= m2_r;
      for (int i = 0; i < NJ; i++) begin
        num = jmsv_pkg::NUM_W'(abs2_r[i]) * jmsv_pkg::NUM_W'(gain)
            + (jmsv_pkg::NUM_W'(m2_r) << 13);
        s3_r.lane[i].rem <= num[jmsv_pkg::FRAC_SH +: jmsv_pkg::REM_W];
        s3_r.lane[i].quo <= '0;
        s3_r.lane[i].neg <= neg2_r[i];
      end
    end
  end

  assign chain[0] = s3_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    jmsv_div_step #(.BIT(QW - 1 - k)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .stage_in  (chain[k]),
      .stage_out (chain[k+1])
    );
  end

  // output stage: sign, saturate, zero on arrival
  always_comb begin
    logic [QW-1:0] mag;
    for (int i = 0; i < NJ; i++) begin
      mag = chain[QW].lane[i].quo;
      if (chain[QW].arrived) begin
        vel_nxt[i] = '0;
      end else if (chain[QW].lane[i].neg) begin
        vel_nxt[i] = (mag > QW'(65536)) ? jmsv_pkg::VEL_W'(17'h10000)
                                        : -jmsv_pkg::VEL_W'(mag);
      end else begin
        vel_nxt[i] = (mag > QW'(65535)) ? jmsv_pkg::VEL_W'(17'h0FFFF)
                                        : jmsv_pkg::VEL_W'(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_arr_r <= chain[QW].arrived;
      vel_r     <= vel_nxt;
    end
  end

  assign out_.valid      = out_v_r;
  assign out_.arrived    = out_arr_r;
  assign out_.velocity_0 = vel_r[0];
  assign out_.velocity_1 = vel_r[1];
  assign out_.velocity_2 = vel_r[2];
  assign out_.velocity_3 = vel_r[3];
  assign out_.velocity_4 = vel_r[4];
  assign out_.velocity_5 = vel_r[5];
endmodule
